### hdl/msbfr_pkg.sv
// shared types and constants for the msb-first bit field reader
`default_nettype none

package msbfr_pkg;

  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUF_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_OFFS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN  = 2'd2;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [12:0] BUF_LEN_RST  = 13'd4096;
  localparam logic [11:0] WIN_OFFS_RST = 12'd0;
  localparam logic [12:0] WIN_LEN_RST  = 13'd4096;

  localparam logic [6:0] MAX_COUNT = 7'd64;

  typedef logic [63:0] word_t;

endpackage

`default_nettype wire

### hdl/msb_first_bit_field_reader_unit.sv
// msb-first bit field reader: two-bank byte store, window checks and field extraction
//
// Input channel (in_valid / in_stall): a load transaction writes in_load_byte at
// in_load_addr, a read transaction extracts in_bit_count bits (1 to 64) msb-first
// from the window at the current bit position and, if it succeeds, advances the position.
// Every transaction yields one result on the output channel (out_valid / out_stall):
// out_read_value right-aligned, out_status 0 ok, 1 bad count, 2 out of range.
// The byte store is two synchronous memories of 64-bit words (even and odd word
// banks), so a field spanning up to nine bytes is fetched in one read of both banks.
// out_valid rises once the memory read and the shift into the output register are
// done, and the result can be taken from then on; one transaction is in flight at a
// time, so the block accepts no new transaction until the result of the last one is
// in the output register.
// The output register holds a stalled result; while it is stalled no new
// transaction is accepted. Reset clears the position, the valid flags and the
// window registers to their defaults (buffer 4096, offset 0, window 4096); the
// store contents are undefined until loaded. A cfg_we write to index 0..2 updates
// that register and sets the bit position back to 0; other indexes are ignored.
`default_nettype none

module msb_first_bit_field_reader_unit #(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        in_req_type,
  input  wire logic [11:0] in_load_addr,
  input  wire logic [7:0]  in_load_byte,
  input  wire logic [6:0]  in_bit_count,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [63:0] out_read_value,
  output      logic [1:0]  out_status,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_wdata
);

  localparam int unsigned WORDS      = (STORE_BYTES + 7) / 8;
  localparam int unsigned BANK_DEPTH = (WORDS + 1) / 2;
  localparam int unsigned BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // control and configuration state
  logic        busy_r;
  logic        out_valid_r;
  logic [15:0] bit_pos_r;
  logic [12:0] buf_len_r;
  logic [11:0] win_offs_r;
  logic [12:0] win_len_r;

  // request captured at accept
  logic                          rd_ok_r;
  logic [msbfr_pkg::STATUS_W-1:0] status_r;
  logic [6:0]                    count_r;
  logic [5:0]                    shift_r;
  logic [10:0]                   word_r;

  logic [63:0]                   out_value_r;
  logic [msbfr_pkg::STATUS_W-1:0] out_status_r;

  // two banks of 64-bit words, byte at lowest address in the top lane
  msbfr_pkg::word_t mem_even [BANK_DEPTH];
  msbfr_pkg::word_t mem_odd  [BANK_DEPTH];
  msbfr_pkg::word_t even_q;
  msbfr_pkg::word_t odd_q;

  logic in_accept;
  logic out_accept;
  logic cfg_hit;

  // accept-time checks
  logic                          bad_count;
  logic [13:0]                   win_end;
  logic                          win_bad;
  logic [16:0]                   pos_end;
  logic [16:0]                   win_bits;
  logic                          past_end;
  logic [msbfr_pkg::STATUS_W-1:0] status_nxt;
  logic                          rd_ok_nxt;
  logic [16:0]                   abs_bit;
  logic [10:0]                   word_idx;
  logic [15:0]                   even_idx_full;
  logic [15:0]                   odd_idx_full;
  logic [BANK_AW-1:0]            even_rd_idx;
  logic [BANK_AW-1:0]            odd_rd_idx;

  // load path
  logic                          load_en;
  logic [15:0]                   load_idx_full;
  logic [BANK_AW-1:0]            load_idx;
  logic [2:0]                    load_lane;

  // extraction
  logic [127:0]                  win_data;
  logic [127:0]                  win_masked;
  logic [127:0]                  win_shift;
  logic [6:0]                    rshift;
  logic [63:0]                   value_nxt;
  logic [16:0]                   lane_addr;

  assign in_stall   = busy_r || (out_valid_r && out_stall);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid_r && !out_stall;
  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;

  assign cfg_hit = cfg_we && ((cfg_index == msbfr_pkg::CFG_BUF_LEN) ||
                              (cfg_index == msbfr_pkg::CFG_WIN_OFFS) ||
                              (cfg_index == msbfr_pkg::CFG_WIN_LEN));

  always_comb begin
    bad_count = (in_bit_count == 7'd0) || (in_bit_count > msbfr_pkg::MAX_COUNT);
    win_end   = 14'(win_offs_r) + 14'(win_len_r);
    win_bad   = win_end > 14'(buf_len_r);
    pos_end   = 17'(bit_pos_r) + 17'(in_bit_count);
    win_bits  = {1'b0, win_len_r, 3'b000};
    past_end  = pos_end > win_bits;
    rd_ok_nxt = 1'b0;
    if (in_req_type == msbfr_pkg::REQ_LOAD) begin
      status_nxt = msbfr_pkg::ST_OK;
    end else if (bad_count) begin
      status_nxt = msbfr_pkg::ST_BAD_COUNT;
    end else if (win_bad || past_end) begin
      status_nxt = msbfr_pkg::ST_RANGE;
    end else begin
      status_nxt = msbfr_pkg::ST_OK;
      rd_ok_nxt  = 1'b1;
    end
  end

  // first word of the field and the bank addresses for it and the next word
  always_comb begin
    abs_bit       = {2'b00, win_offs_r, 3'b000} + 17'(bit_pos_r);
    word_idx      = abs_bit[16:6];
    even_idx_full = 16'(word_idx[10:1]) + 16'(word_idx[0]);
    odd_idx_full  = 16'(word_idx[10:1]);
    even_rd_idx   = even_idx_full[BANK_AW-1:0];
    odd_rd_idx    = odd_idx_full[BANK_AW-1:0];
  end

  always_comb begin
    load_en       = in_accept && (in_req_type == msbfr_pkg::REQ_LOAD) &&
                    (17'(in_load_addr) < 17'(STORE_BYTES));
    load_idx_full = 16'(in_load_addr) >> 4;
    load_idx      = load_idx_full[BANK_AW-1:0];
    load_lane     = 3'd7 - in_load_addr[2:0];
  end

  always_ff @(posedge clk) begin
    if (load_en && !in_load_addr[3]) begin
      mem_even[load_idx][load_lane*8 +: 8] <= in_load_byte;
    end
    even_q <= mem_even[even_rd_idx];
  end

  always_ff @(posedge clk) begin
    if (load_en && in_load_addr[3]) begin
      mem_odd[load_idx][load_lane*8 +: 8] <= in_load_byte;
    end
    odd_q <= mem_odd[odd_rd_idx];
  end

  // bytes at or beyond the store end read as zero
  always_comb begin
    win_data = word_r[0] ? {odd_q, even_q} : {even_q, odd_q};
    lane_addr = '0;
    for (int k = 0; k < 16; k++) begin
      lane_addr = {3'b000, word_r, 3'b000} + 17'(k);
      win_masked[127-8*k -: 8] = (lane_addr < 17'(STORE_BYTES)) ?
                                 win_data[127-8*k -: 8] : 8'd0;
    end
    win_shift = win_masked << shift_r;
    rshift    = msbfr_pkg::MAX_COUNT - count_r;
    value_nxt = rd_ok_r ? (win_shift[127:64] >> rshift) : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_ok_r  <= rd_ok_nxt;
      status_r <= status_nxt;
      count_r  <= in_bit_count;
      shift_r  <= abs_bit[5:0];
      word_r   <= word_idx;
    end
    if (busy_r) begin
      out_value_r  <= value_nxt;
      out_status_r <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      bit_pos_r   <= '0;
      buf_len_r   <= msbfr_pkg::BUF_LEN_RST;
      win_offs_r  <= msbfr_pkg::WIN_OFFS_RST;
      win_len_r   <= msbfr_pkg::WIN_LEN_RST;
    end else begin
      busy_r <= in_accept;
      if (busy_r) begin
        out_valid_r <= 1'b1;
      end else if (out_accept) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_hit) begin
        bit_pos_r <= '0;
      end else if (in_accept && rd_ok_nxt) begin
        bit_pos_r <= bit_pos_r + 16'(in_bit_count);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          msbfr_pkg::CFG_BUF_LEN:  buf_len_r  <= cfg_wdata;
          msbfr_pkg::CFG_WIN_OFFS: win_offs_r <= cfg_wdata[11:0];
          msbfr_pkg::CFG_WIN_LEN:  win_len_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // output register is empty while a transaction is being worked on
  a_busy_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !out_valid_r)
    else $error("result register occupied during fetch");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> busy_r)
    else $error("accepted transaction not in flight");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != msbfr_pkg::ST_OK)) |-> (out_value_r == 64'd0))
    else $error("nonzero value with error status");

  // a failing read or a load leaves the position where it was
  a_error_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !rd_ok_nxt && !cfg_hit) |=> (bit_pos_r == $past(bit_pos_r)))
    else $error("position moved on a failed or load transaction");

endmodule

`default_nettype wire
